/* rtl/s2g_pkg.sv */
// Shared types and constants for the Shift-JIS to glyph index mapper.
// Used by the mapping logic and the top level; no dependencies.
`default_nettype none

package s2g_pkg;

  // Font mode register codes. The fourth code behaves as the large font.
  typedef enum logic [1:0] {
    MODE_SMALL     = 2'd0,
    MODE_LARGE     = 2'd1,
    MODE_ALT       = 2'd2,
    MODE_LARGE_ALT = 2'd3
  } glyph_mode_e;

  localparam int unsigned CodeW  = 16;
  localparam int unsigned ByteW  = 8;

  // Lead byte of the end-of-text marker and lead bytes of the rows that carry glyphs.
  localparam logic [ByteW-1:0] LeadEnd    = 8'h00;
  localparam logic [ByteW-1:0] LeadSymbol = 8'h81;
  localparam logic [ByteW-1:0] LeadKana   = 8'h82;
  localparam logic [ByteW-1:0] LeadKata   = 8'h83;

  // Alternate table offsets.
  localparam logic [CodeW-1:0] AltOffs81 = 16'h7EC0;
  localparam logic [CodeW-1:0] AltOffs82 = 16'h7DC0;
  localparam logic [CodeW-1:0] AltBit82  = 16'h0400;

  // One result beat.
  typedef struct packed {
    logic [CodeW-1:0] glyph_index;
    logic             matched;
    logic             end_of_text;
  } glyph_res_t;

endpackage

`default_nettype wire

/* rtl/s2g_code_if.sv */
// Handshake channel that carries one Shift-JIS character code per beat.
// Depends on nothing.
`default_nettype none

interface s2g_code_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

/* rtl/s2g_glyph_if.sv */
// Handshake channel that carries one glyph result per beat.
// Depends on nothing.
`default_nettype none

interface s2g_glyph_if;
  logic        valid;
  logic        ready;
  logic [15:0] glyph_index;
  logic        matched;
  logic        end_of_text;

  modport source (output valid, output glyph_index, output matched, output end_of_text,
                  input ready);
  modport sink   (input valid, input glyph_index, input matched, input end_of_text,
                  output ready);
endinterface

`default_nettype wire

/* rtl/sjis_to_glyph_index.sv */
// Top level of the Shift-JIS to glyph index mapper.
// Depends on s2g_pkg, s2g_code_if, s2g_glyph_if and s2g_map.
`default_nettype none

// Maps each two-byte Shift-JIS code beat to a glyph index beat. One beat is
// accepted per clock cycle when not stalled; each beat passes through the
// input register and then the result register, with the mapping logic
// between them. Back-pressure on the result channel stalls both stages; the
// pipeline keeps accepting while a stage ahead can move. The font mode register
// (0 small, 1 large, 2 alternate table, 3 as large) is written with cfg_we_i
// and should only change while no beat is in flight.
module sjis_to_glyph_index (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_wdata_i,
  s2g_code_if.sink        code_i,
  s2g_glyph_if.source     glyph_o
);
  import s2g_pkg::*;

  glyph_mode_e      mode_q;
  logic [CodeW-1:0] code_q;
  logic             code_vld_q;
  glyph_res_t       res_d;
  glyph_res_t       res_q;
  logic             res_vld_q;
  logic             res_en;
  logic             code_en;

  // Stage enables: a stage loads when it is empty or its contents move on.
  assign res_en       = !res_vld_q || glyph_o.ready;
  assign code_en      = !code_vld_q || res_en;
  assign code_i.ready = code_en;

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SMALL;
    end else if (cfg_we_i) begin
      mode_q <= glyph_mode_e'(cfg_wdata_i);
    end
  end

  // Input stage valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_vld_q <= 1'b0;
    end else if (code_en) begin
      code_vld_q <= code_i.valid;
    end
  end

  // Input stage payload.
  always_ff @(posedge clk_i) begin
    if (code_en && code_i.valid) begin
      code_q <= code_i.char_code;
    end
  end

  s2g_map u_map (
    .code_i (code_q),
    .mode_i (mode_q),
    .res_o  (res_d)
  );

  // Result stage valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_en) begin
      res_vld_q <= code_vld_q;
    end
  end

  // Result stage payload.
  always_ff @(posedge clk_i) begin
    if (res_en && code_vld_q) begin
      res_q <= res_d;
    end
  end

  assign glyph_o.valid       = res_vld_q;
  assign glyph_o.glyph_index = res_q.glyph_index;
  assign glyph_o.matched     = res_q.matched;
  assign glyph_o.end_of_text = res_q.end_of_text;

endmodule

`default_nettype wire

/* rtl/s2g_map.sv */
// Combinational mapping of one character code to a glyph result.
// Depends on s2g_pkg.
`default_nettype none

module s2g_map (
  input  logic [15:0]         code_i,
  input  s2g_pkg::glyph_mode_e mode_i,
  output s2g_pkg::glyph_res_t  res_o
);
  import s2g_pkg::*;

  logic [ByteW-1:0] lead;
  logic [ByteW-1:0] trail;
  logic             half;
  logic             sym_hit;
  logic [4:0]       sym_glyph;
  logic             font_hit;
  logic [CodeW-1:0] font_glyph;
  logic [CodeW-1:0] alt_glyph;
  logic             alt_hit;
  logic             eot;

  // Fixed list of punctuation and symbols in the 0x81 row.
  function automatic logic [5:0] sym_lookup(input logic [ByteW-1:0] t);
    logic [5:0] r;
    r = '0;
    unique case (t)
      8'h40: r = {1'b1, 5'd0};
      8'h5E: r = {1'b1, 5'd1};
      8'h5B: r = {1'b1, 5'd2};
      8'h5C: r = {1'b1, 5'd2};
      8'h5D: r = {1'b1, 5'd2};
      8'h51: r = {1'b1, 5'd3};
      8'h44: r = {1'b1, 5'd4};
      8'h7B: r = {1'b1, 5'd5};
      8'h49: r = {1'b1, 5'd6};
      8'h48: r = {1'b1, 5'd7};
      8'h94: r = {1'b1, 5'd8};
      8'h93: r = {1'b1, 5'd9};
      8'h8D: r = {1'b1, 5'd10};
      8'h8B: r = {1'b1, 5'd11};
      8'h96: r = {1'b1, 5'd12};
      8'h68: r = {1'b1, 5'd13};
      8'h90: r = {1'b1, 5'd14};
      8'h95: r = {1'b1, 5'd15};
      8'h66: r = {1'b1, 5'd16};
      8'h69: r = {1'b1, 5'd17};
      8'h6A: r = {1'b1, 5'd18};
      8'h81: r = {1'b1, 5'd19};
      8'h60: r = {1'b1, 5'd20};
      8'h62: r = {1'b1, 5'd21};
      8'h97: r = {1'b1, 5'd22};
      8'h65: r = {1'b1, 5'd23};
      8'h75: r = {1'b1, 5'd24};
      8'h76: r = {1'b1, 5'd25};
      8'h6F: r = {1'b1, 5'd26};
      8'h70: r = {1'b1, 5'd27};
      8'h41: r = {1'b1, 5'd28};
      8'h42: r = {1'b1, 5'd29};
      8'h83: r = {1'b1, 5'd30};
      8'h84: r = {1'b1, 5'd31};
      default: r = '0;
    endcase
    return r;
  endfunction

  // Offset from the start of a range plus a base that the small font halves.
  function automatic logic [CodeW-1:0] span_glyph(input logic [ByteW-1:0] t,
                                                  input logic [ByteW-1:0] first,
                                                  input logic [CodeW-1:0] base,
                                                  input logic             h);
    logic [CodeW-1:0] b;
    b = h ? (base >> 1) : base;
    return {{(CodeW-ByteW){1'b0}}, t - first} + b;
  endfunction

  assign lead  = code_i[15:8];
  assign trail = code_i[7:0];
  assign half  = (mode_i == MODE_SMALL);
  assign eot   = (lead == LeadEnd);
  assign {sym_hit, sym_glyph} = sym_lookup(trail);

  // Small and large font rules.
  always_comb begin
    font_hit   = 1'b0;
    font_glyph = '0;
    unique case (lead)
      LeadSymbol: begin
        if (sym_hit) begin
          font_hit   = 1'b1;
          font_glyph = {{(CodeW-5){1'b0}}, sym_glyph};
        end else if (trail > 8'h46) begin
          font_hit   = 1'b1;
          font_glyph = span_glyph(trail, 8'h46, 16'h0042, half);
        end
      end
      LeadKana: begin
        font_hit = 1'b1;
        priority if (trail >= 8'h4F && trail <= 8'h58)
          font_glyph = span_glyph(trail, 8'h4F, 16'h0080, half);
        else if (trail >= 8'h60 && trail <= 8'h79)
          font_glyph = span_glyph(trail, 8'h60, 16'h00C0, half);
        else if (trail >= 8'h81 && trail <= 8'h9A)
          font_glyph = span_glyph(trail, 8'h81, 16'h0100, half);
        else if (trail >= 8'h9F && trail <= 8'hBE)
          font_glyph = span_glyph(trail, 8'h9F, 16'h0140, half);
        else if (trail >= 8'hBF && trail <= 8'hDE)
          font_glyph = span_glyph(trail, 8'hBF, 16'h0180, half);
        else if (trail >= 8'hDF && trail <= 8'hFE)
          font_glyph = span_glyph(trail, 8'hDF, 16'h01C0, half);
        else
          font_hit = 1'b0;
      end
      LeadKata: begin
        // The small font also pulls katakana bases down by 0xC0 before halving, except for trails 0xBF-0xC0.
        font_hit = 1'b1;
        priority if (trail >= 8'h40 && trail <= 8'h5F)
          font_glyph = span_glyph(trail, 8'h40, half ? 16'h0140 : 16'h0200, half);
        else if (trail >= 8'h60 && trail <= 8'h7E)
          font_glyph = span_glyph(trail, 8'h60, half ? 16'h0180 : 16'h0240, half);
        else if (trail == 8'h80)
          font_glyph = half ? 16'h00CF : 16'h025F;
        else if (trail >= 8'h81 && trail <= 8'h96)
          font_glyph = span_glyph(trail, 8'h81, half ? 16'h01C0 : 16'h0280, half);
        else if (trail >= 8'hBF && trail <= 8'hC0)
          font_glyph = span_glyph(trail, 8'hBF, 16'h0040, half);
        else
          font_hit = 1'b0;
      end
      default: begin
        font_hit   = 1'b0;
        font_glyph = '0;
      end
    endcase
  end

  // Alternate table: rows 0x81 and 0x82 only.
  always_comb begin
    alt_hit   = 1'b0;
    alt_glyph = '0;
    if (lead == LeadSymbol) begin
      alt_hit   = 1'b1;
      alt_glyph = code_i + AltOffs81;
    end else if (lead == LeadKana) begin
      alt_hit   = 1'b1;
      alt_glyph = (code_i + AltOffs82) | AltBit82;
    end
  end

  // Select by mode and clear the index when nothing applied.
  always_comb begin
    res_o.end_of_text = eot;
    res_o.matched     = 1'b0;
    res_o.glyph_index = '0;
    if (!eot) begin
      unique case (mode_i)
        MODE_ALT: begin
          res_o.matched     = alt_hit;
          res_o.glyph_index = alt_hit ? alt_glyph : '0;
        end
        MODE_SMALL, MODE_LARGE, MODE_LARGE_ALT: begin
          res_o.matched     = font_hit;
          res_o.glyph_index = font_hit ? font_glyph : '0;
        end
        default: begin
          res_o.matched     = 1'b0;
          res_o.glyph_index = '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
